// ===== sv/mrpm_pkg.sv =====
package mrpm_pkg;

   localparam int RX_DEPTH       = 64;
   localparam int RX_AW          = $clog2(RX_DEPTH);
   localparam int RX_LW          = $clog2(RX_DEPTH + 1);
   localparam int READ_REG_COUNT = 9;
   localparam int WRITE_RETRY_LIMIT = 5;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [7:0]  FUNC_READ  = 8'h03;
   localparam logic [7:0]  FUNC_WRITE = 8'h06;
   localparam logic [7:0]  READ_BYTE_COUNT = 8'(2 * READ_REG_COUNT);
   localparam logic [RX_LW-1:0] MIN_FRAME_LEN   = RX_LW'(5);
   localparam logic [RX_LW-1:0] READ_FRAME_LEN  = RX_LW'(5 + 2 * READ_REG_COUNT);
   localparam logic [RX_LW-1:0] WRITE_FRAME_LEN = RX_LW'(8);

   localparam logic [2:0] MODE_TICK    = 3'd0;
   localparam logic [2:0] MODE_BYTE    = 3'd1;
   localparam logic [2:0] MODE_FLOOR   = 3'd2;
   localparam logic [2:0] MODE_CLR_EMG = 3'd3;
   localparam logic [2:0] MODE_INSP_ON = 3'd4;
   localparam logic [2:0] MODE_INSP_OFF = 3'd5;

   localparam logic [1:0] KIND_TX      = 2'd0;
   localparam logic [1:0] KIND_REG     = 2'd1;
   localparam logic [1:0] KIND_OUTCOME = 2'd2;

   localparam logic [1:0] OC_READ_OK  = 2'd0;
   localparam logic [1:0] OC_WRITE_OK = 2'd1;
   localparam logic [1:0] OC_BAD      = 2'd2;
   localparam logic [1:0] OC_TIMEOUT  = 2'd3;

   localparam logic [1:0] RK_READ   = 2'd0;
   localparam logic [1:0] RK_TARGET = 2'd1;
   localparam logic [1:0] RK_EMG    = 2'd2;
   localparam logic [1:0] RK_INSP   = 2'd3;

   localparam logic [2:0] REG_SLAVE   = 3'd0;
   localparam logic [2:0] REG_POLL    = 3'd1;
   localparam logic [2:0] REG_TIMEOUT = 3'd2;
   localparam logic [2:0] REG_GAP     = 3'd3;
   localparam logic [2:0] REG_MAXFAIL = 3'd4;
   localparam logic [2:0] REG_TARGET  = 3'd5;
   localparam logic [2:0] REG_EMG     = 3'd6;
   localparam logic [2:0] REG_INSP    = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEND,
      ST_CHK_RD,
      ST_CHK_USE,
      ST_VERDICT,
      ST_REG_HI_RD,
      ST_REG_HI,
      ST_REG_LO,
      ST_OUTCOME
   } state_type;

   typedef struct packed {
      logic       init;
      logic       en;
      logic [7:0] data;
   } crc_ctl_type;

   typedef struct packed {
      logic             wr_en;
      logic [RX_AW-1:0] wr_addr;
      logic [7:0]       wr_data;
      logic             rd_en;
      logic [RX_AW-1:0] rd_addr;
   } mem_ctl_type;

endpackage

// ===== sv/mrpm_crc.sv =====
module mrpm_crc (
   input  logic                 clock,
   input  mrpm_pkg::crc_ctl_type ctl,
   output logic [15:0]          crc
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic [15:0] acc;

   // one byte per cycle, eight shift steps
   always_comb begin
      acc = crc_ff ^ {8'd0, ctl.data};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) acc = (acc >> 1) ^ mrpm_pkg::CRC_POLY;
         else acc = acc >> 1;
      end
      if (ctl.init) crc_in = mrpm_pkg::CRC_INIT;
      else if (ctl.en) crc_in = acc;
      else crc_in = crc_ff;
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign crc = crc_ff;

endmodule

// ===== sv/mrpm_rxbuf.sv =====
module mrpm_rxbuf (
   input  logic                 clock,
   input  mrpm_pkg::mem_ctl_type ctl,
   output logic [7:0]           rd_data
);

   logic [7:0] mem [mrpm_pkg::RX_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) mem[ctl.wr_addr] <= ctl.wr_data;
      if (ctl.rd_en) rd_data_ff <= mem[ctl.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/modbus_rtu_polling_master_core.sv =====
// channel   dir  tdata                                   tuser
// req_      in   rx_byte[7:0] floor_value[15:8]          mode[2:0]
// rsp_      out  tx_byte, reg_index, reg_value,          out_kind[1:0]
//                outcome, link_ok (31 bits in 32)
// csr_      apb  8 registers at 4*i, write/read, pready tied high
//
// non-tick items and ticks that start nothing leave the core idle and ready for the next item
// a request frame goes out as eight tx words, held back by output stalls
// closing a frame walks the rx buffer with a read and a use state per byte
// (registered ram read), then high read, high and low states per word read back
// req_tready is low while an item is being worked; rsp_ has a one-word output register
// synchronous reset; the rx buffer has no reset, only filled entries are read
module modbus_rtu_polling_master_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // rx_byte[7:0], floor_value[15:8]
   input  logic [2:0]  req_tuser,   // mode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // tx_byte[7:0], reg_index[11:8], reg_value[27:12],
                                    // outcome[29:28], link_ok[30], zero[31]
   output logic [1:0]  rsp_tuser,   // out_kind[1:0]
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = mrpm_pkg::RX_AW;
   localparam int LW = mrpm_pkg::RX_LW;

   // configuration
   logic [7:0]  slave_ff, gap_ff, maxfail_ff;
   logic [15:0] poll_ff, tmo_ff, treg_ff, ereg_ff, ireg_ff;
   logic        csr_we;

   assign csr_pready = 1'b1;
   assign csr_we = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_ff <= 8'd1;
         poll_ff <= 16'd200;
         tmo_ff <= 16'd100;
         gap_ff <= 8'd5;
         maxfail_ff <= 8'd3;
         treg_ff <= 16'd1;
         ereg_ff <= 16'd3;
         ireg_ff <= 16'd7;
      end else if (csr_we) begin
         case (csr_paddr[4:2])
            mrpm_pkg::REG_SLAVE:   slave_ff <= csr_pwdata[7:0];
            mrpm_pkg::REG_POLL:    poll_ff <= csr_pwdata[15:0];
            mrpm_pkg::REG_TIMEOUT: tmo_ff <= csr_pwdata[15:0];
            mrpm_pkg::REG_GAP:     gap_ff <= csr_pwdata[7:0];
            mrpm_pkg::REG_MAXFAIL: maxfail_ff <= csr_pwdata[7:0];
            mrpm_pkg::REG_TARGET:  treg_ff <= csr_pwdata[15:0];
            mrpm_pkg::REG_EMG:     ereg_ff <= csr_pwdata[15:0];
            mrpm_pkg::REG_INSP:    ireg_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         mrpm_pkg::REG_SLAVE:   csr_prdata = {24'd0, slave_ff};
         mrpm_pkg::REG_POLL:    csr_prdata = {16'd0, poll_ff};
         mrpm_pkg::REG_TIMEOUT: csr_prdata = {16'd0, tmo_ff};
         mrpm_pkg::REG_GAP:     csr_prdata = {24'd0, gap_ff};
         mrpm_pkg::REG_MAXFAIL: csr_prdata = {24'd0, maxfail_ff};
         mrpm_pkg::REG_TARGET:  csr_prdata = {16'd0, treg_ff};
         mrpm_pkg::REG_EMG:     csr_prdata = {16'd0, ereg_ff};
         mrpm_pkg::REG_INSP:    csr_prdata = {16'd0, ireg_ff};
         default:               csr_prdata = 32'd0;
      endcase
   end

   // control state
   mrpm_pkg::state_type state_ff, state_in;
   logic [LW-1:0] rx_len_ff, rx_len_in, flen_ff, flen_in;
   logic [7:0]  tsb_ff, tsb_in, fail_ff, fail_in, wfail_ff, wfail_in, pfloor_ff, pfloor_in;
   logic [15:0] tsp_ff, tsp_in, tss_ff, tss_in;
   logic        wait_ff, wait_in, link_ff, link_in, pinsp_ff, pinsp_in, bad_ff, bad_in;
   logic [1:0]  rk_ff, rk_in, oc_ff, oc_in;
   logic [2:0]  pend_ff, pend_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [15:0] raddr_ff, raddr_in, rval_ff, rval_in, rcv_ff, rcv_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in, rsp_link_ff, rsp_link_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in, rsp_oc_ff, rsp_oc_in;
   logic [7:0]  rsp_tx_ff, rsp_tx_in;
   logic [3:0]  rsp_idx_ff, rsp_idx_in;
   logic [15:0] rsp_val_ff, rsp_val_in;

   mrpm_pkg::crc_ctl_type crc_ctl;
   mrpm_pkg::mem_ctl_type mem_ctl;
   logic [15:0] crc;
   logic [7:0]  rd_data;

   mrpm_crc u_crc (.clock(clock), .ctl(crc_ctl), .crc(crc));
   mrpm_rxbuf u_rxbuf (.clock(clock), .ctl(mem_ctl), .rd_data(rd_data));

   logic        acc, rsp_free;
   logic [2:0]  mode;
   logic [15:0] tsp_t, tss_t;
   logic [7:0]  tsb_t, fail_t, frame_byte;
   logic        send_go, close_go, tmo_go, frame_ok;
   logic [LW-1:0] idx_ext;

   assign req_tready = (state_ff == mrpm_pkg::ST_IDLE);
   assign acc = req_tvalid & req_tready;
   assign mode = req_tuser;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign idx_ext = LW'(idx_ff);

   assign tsp_t = (tsp_ff == 16'hFFFF) ? tsp_ff : tsp_ff + 16'd1;
   assign tsb_t = (tsb_ff == 8'hFF) ? tsb_ff : tsb_ff + 8'd1;
   assign tss_t = (wait_ff && tss_ff != 16'hFFFF) ? tss_ff + 16'd1 : tss_ff;
   assign fail_t = (fail_ff == 8'hFF) ? fail_ff : fail_ff + 8'd1;
   assign send_go = !wait_ff && (tsp_t >= poll_ff);
   assign close_go = wait_ff && (rx_len_ff != '0) && (tsb_t >= gap_ff);
   assign tmo_go = wait_ff && !close_go && (tss_t >= tmo_ff);

   assign frame_ok = !bad_ff && (crc == rcv_ff) &&
                     ((rk_ff == mrpm_pkg::RK_READ) ? (flen_ff >= mrpm_pkg::READ_FRAME_LEN)
                                                   : (flen_ff >= mrpm_pkg::WRITE_FRAME_LEN));

   always_comb begin
      case (idx_ff[2:0])
         3'd0:    frame_byte = slave_ff;
         3'd1:    frame_byte = (rk_ff == mrpm_pkg::RK_READ) ? mrpm_pkg::FUNC_READ
                                                            : mrpm_pkg::FUNC_WRITE;
         3'd2:    frame_byte = raddr_ff[15:8];
         3'd3:    frame_byte = raddr_ff[7:0];
         3'd4:    frame_byte = rval_ff[15:8];
         3'd5:    frame_byte = rval_ff[7:0];
         3'd6:    frame_byte = crc[7:0];
         default: frame_byte = crc[15:8];
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mrpm_pkg::ST_IDLE: begin
            if (acc && mode == mrpm_pkg::MODE_TICK) begin
               if (send_go) state_in = mrpm_pkg::ST_SEND;
               else if (close_go) begin
                  if (rx_len_ff < mrpm_pkg::MIN_FRAME_LEN) state_in = mrpm_pkg::ST_VERDICT;
                  else state_in = mrpm_pkg::ST_CHK_RD;
               end else if (tmo_go) state_in = mrpm_pkg::ST_OUTCOME;
            end
         end
         mrpm_pkg::ST_SEND:
            if (rsp_free && idx_ff == AW'(7)) state_in = mrpm_pkg::ST_IDLE;
         mrpm_pkg::ST_CHK_RD: state_in = mrpm_pkg::ST_CHK_USE;
         mrpm_pkg::ST_CHK_USE:
            if (idx_ext == flen_ff - LW'(1)) state_in = mrpm_pkg::ST_VERDICT;
            else state_in = mrpm_pkg::ST_CHK_RD;
         mrpm_pkg::ST_VERDICT:
            if (frame_ok && rk_ff == mrpm_pkg::RK_READ) state_in = mrpm_pkg::ST_REG_HI_RD;
            else state_in = mrpm_pkg::ST_OUTCOME;
         mrpm_pkg::ST_REG_HI_RD: state_in = mrpm_pkg::ST_REG_HI;
         mrpm_pkg::ST_REG_HI: state_in = mrpm_pkg::ST_REG_LO;
         mrpm_pkg::ST_REG_LO:
            if (rsp_free) begin
               if (idx_ff == AW'(mrpm_pkg::READ_REG_COUNT - 1)) state_in = mrpm_pkg::ST_OUTCOME;
               else state_in = mrpm_pkg::ST_REG_HI_RD;
            end
         mrpm_pkg::ST_OUTCOME:
            if (rsp_free) state_in = mrpm_pkg::ST_IDLE;
         default: state_in = mrpm_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      rx_len_in = rx_len_ff; flen_in = flen_ff;
      tsb_in = tsb_ff; tsp_in = tsp_ff; tss_in = tss_ff;
      fail_in = fail_ff; wfail_in = wfail_ff; pfloor_in = pfloor_ff;
      wait_in = wait_ff; link_in = link_ff; pinsp_in = pinsp_ff; bad_in = bad_ff;
      rk_in = rk_ff; oc_in = oc_ff; pend_in = pend_ff; idx_in = idx_ff;
      raddr_in = raddr_ff; rval_in = rval_ff; rcv_in = rcv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_last_in = rsp_last_ff; rsp_link_in = rsp_link_ff; rsp_kind_in = rsp_kind_ff;
      rsp_oc_in = rsp_oc_ff; rsp_tx_in = rsp_tx_ff; rsp_idx_in = rsp_idx_ff;
      rsp_val_in = rsp_val_ff;
      crc_ctl = '{init: 1'b0, en: 1'b0, data: 8'd0};
      mem_ctl = '{wr_en: 1'b0, wr_addr: rx_len_ff[AW-1:0], wr_data: req_tdata[7:0],
                  rd_en: 1'b0, rd_addr: idx_ff};

      case (state_ff)
         mrpm_pkg::ST_IDLE: begin
            if (acc) begin
               case (mode)
                  mrpm_pkg::MODE_TICK: begin
                     tsp_in = tsp_t; tsb_in = tsb_t; tss_in = tss_t;
                     if (send_go) begin
                        crc_ctl.init = 1'b1;
                        idx_in = '0;
                        rx_len_in = '0; tsp_in = '0; tss_in = '0; wait_in = 1'b1;
                        if (pend_ff[0]) begin
                           rk_in = mrpm_pkg::RK_TARGET; raddr_in = treg_ff;
                           rval_in = {8'd0, pfloor_ff};
                        end else if (pend_ff[1]) begin
                           rk_in = mrpm_pkg::RK_EMG; raddr_in = ereg_ff; rval_in = 16'd0;
                        end else if (pend_ff[2]) begin
                           rk_in = mrpm_pkg::RK_INSP; raddr_in = ireg_ff;
                           rval_in = {15'd0, pinsp_ff};
                        end else begin
                           rk_in = mrpm_pkg::RK_READ; raddr_in = 16'd0;
                           rval_in = 16'(mrpm_pkg::READ_REG_COUNT);
                        end
                     end else if (close_go) begin
                        crc_ctl.init = 1'b1;
                        flen_in = rx_len_ff;
                        rx_len_in = '0; wait_in = 1'b0;
                        idx_in = '0;
                        bad_in = (rx_len_ff < mrpm_pkg::MIN_FRAME_LEN);
                     end else if (tmo_go) begin
                        rx_len_in = '0; wait_in = 1'b0;
                        fail_in = fail_t;
                        if (fail_t >= maxfail_ff) link_in = 1'b0;
                        if (rk_ff != mrpm_pkg::RK_READ) begin
                           if (wfail_ff + 8'd1 >= 8'(mrpm_pkg::WRITE_RETRY_LIMIT)) begin
                              pend_in = '0; wfail_in = '0;
                           end else wfail_in = wfail_ff + 8'd1;
                        end
                        oc_in = mrpm_pkg::OC_TIMEOUT;
                     end
                  end
                  mrpm_pkg::MODE_BYTE: begin
                     if (rx_len_ff < LW'(mrpm_pkg::RX_DEPTH)) begin
                        mem_ctl.wr_en = 1'b1;
                        rx_len_in = rx_len_ff + LW'(1);
                        tsb_in = '0;
                     end
                  end
                  mrpm_pkg::MODE_FLOOR: begin
                     if (req_tdata[15:8] >= 8'd1 && req_tdata[15:8] <= 8'd3) begin
                        pfloor_in = req_tdata[15:8]; pend_in[0] = 1'b1;
                     end
                  end
                  mrpm_pkg::MODE_CLR_EMG: pend_in[1] = 1'b1;
                  mrpm_pkg::MODE_INSP_ON: begin
                     pinsp_in = 1'b1; pend_in[2] = 1'b1;
                  end
                  mrpm_pkg::MODE_INSP_OFF: begin
                     pinsp_in = 1'b0; pend_in[2] = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         mrpm_pkg::ST_SEND: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1; rsp_kind_in = mrpm_pkg::KIND_TX;
               rsp_tx_in = frame_byte; rsp_idx_in = '0; rsp_val_in = '0;
               rsp_oc_in = '0; rsp_link_in = link_ff;
               rsp_last_in = (idx_ff == AW'(7));
               crc_ctl.en = (idx_ff < AW'(6));
               crc_ctl.data = frame_byte;
               idx_in = idx_ff + AW'(1);
            end
         end
         mrpm_pkg::ST_CHK_RD: mem_ctl.rd_en = 1'b1;
         mrpm_pkg::ST_CHK_USE: begin
            if (idx_ff == AW'(0) && rd_data != slave_ff) bad_in = 1'b1;
            if (idx_ff == AW'(1)) begin
               if (rk_ff == mrpm_pkg::RK_READ) begin
                  if (rd_data != mrpm_pkg::FUNC_READ) bad_in = 1'b1;
               end else if (rd_data != mrpm_pkg::FUNC_WRITE) bad_in = 1'b1;
            end
            if (idx_ff == AW'(2) && rk_ff == mrpm_pkg::RK_READ &&
                rd_data != mrpm_pkg::READ_BYTE_COUNT) bad_in = 1'b1;
            crc_ctl.en = (idx_ext < flen_ff - LW'(2));
            crc_ctl.data = rd_data;
            if (idx_ext == flen_ff - LW'(2)) rcv_in[7:0] = rd_data;
            if (idx_ext == flen_ff - LW'(1)) rcv_in[15:8] = rd_data;
            idx_in = idx_ff + AW'(1);
         end
         mrpm_pkg::ST_VERDICT: begin
            idx_in = '0;
            if (frame_ok) begin
               link_in = 1'b1; fail_in = '0; wfail_in = '0;
               if (rk_ff == mrpm_pkg::RK_READ) oc_in = mrpm_pkg::OC_READ_OK;
               else begin
                  oc_in = mrpm_pkg::OC_WRITE_OK;
                  case (rk_ff)
                     mrpm_pkg::RK_TARGET: pend_in[0] = 1'b0;
                     mrpm_pkg::RK_EMG:    pend_in[1] = 1'b0;
                     default:             pend_in[2] = 1'b0;
                  endcase
               end
            end else begin
               oc_in = mrpm_pkg::OC_BAD;
               if (rk_ff != mrpm_pkg::RK_READ) begin
                  if (wfail_ff + 8'd1 >= 8'(mrpm_pkg::WRITE_RETRY_LIMIT)) begin
                     pend_in = '0; wfail_in = '0;
                  end else wfail_in = wfail_ff + 8'd1;
               end
            end
         end
         mrpm_pkg::ST_REG_HI_RD: begin
            mem_ctl.rd_en = 1'b1;
            mem_ctl.rd_addr = AW'(3) + {idx_ff[AW-2:0], 1'b0};
         end
         mrpm_pkg::ST_REG_HI: begin
            rcv_in[15:8] = rd_data;
            mem_ctl.rd_en = 1'b1;
            mem_ctl.rd_addr = AW'(4) + {idx_ff[AW-2:0], 1'b0};
         end
         mrpm_pkg::ST_REG_LO: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1; rsp_kind_in = mrpm_pkg::KIND_REG;
               rsp_tx_in = '0; rsp_idx_in = idx_ff[3:0]; rsp_val_in = {rcv_ff[15:8], rd_data};
               rsp_oc_in = '0; rsp_link_in = link_ff; rsp_last_in = 1'b0;
               idx_in = idx_ff + AW'(1);
            end
         end
         mrpm_pkg::ST_OUTCOME: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1; rsp_kind_in = mrpm_pkg::KIND_OUTCOME;
               rsp_tx_in = '0; rsp_idx_in = '0; rsp_val_in = '0;
               rsp_oc_in = oc_ff; rsp_link_in = link_ff; rsp_last_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrpm_pkg::ST_IDLE;
         rx_len_ff <= '0; tsb_ff <= '0; tsp_ff <= '0; tss_ff <= '0;
         wait_ff <= 1'b0; rk_ff <= mrpm_pkg::RK_READ; fail_ff <= '0; wfail_ff <= '0;
         link_ff <= 1'b0; pend_ff <= '0; pfloor_ff <= '0; pinsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rx_len_ff <= rx_len_in; tsb_ff <= tsb_in; tsp_ff <= tsp_in; tss_ff <= tss_in;
         wait_ff <= wait_in; rk_ff <= rk_in; fail_ff <= fail_in; wfail_ff <= wfail_in;
         link_ff <= link_in; pend_ff <= pend_in; pfloor_ff <= pfloor_in; pinsp_ff <= pinsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      flen_ff <= flen_in; bad_ff <= bad_in; oc_ff <= oc_in; idx_ff <= idx_in;
      raddr_ff <= raddr_in; rval_ff <= rval_in; rcv_ff <= rcv_in;
      rsp_last_ff <= rsp_last_in; rsp_link_ff <= rsp_link_in; rsp_kind_ff <= rsp_kind_in;
      rsp_oc_ff <= rsp_oc_in; rsp_tx_ff <= rsp_tx_in; rsp_idx_ff <= rsp_idx_in;
      rsp_val_ff <= rsp_val_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_kind_ff;
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tdata = {1'b0, rsp_link_ff, rsp_oc_ff, rsp_val_ff, rsp_idx_ff, rsp_tx_ff};

`ifndef ASSERT_OFF
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rx_len_ff <= LW'(mrpm_pkg::RX_DEPTH))
      else $error("rx length beyond buffer depth");

   a_send_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mrpm_pkg::ST_SEND && rsp_free && idx_ff == AW'(7))
      |=> (state_ff == mrpm_pkg::ST_IDLE && rsp_tvalid && rsp_tlast))
      else $error("request frame did not end with last word");

   a_wait_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(wait_ff) |-> (state_ff == mrpm_pkg::ST_SEND && rx_len_ff == '0))
      else $error("waiting set outside of a request");

   a_link_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(link_ff) |-> $past(state_ff) == mrpm_pkg::ST_VERDICT)
      else $error("link came up without a good frame");
`endif

endmodule

// ===== dv/modbus_rtu_polling_master_core_tb.sv =====
`timescale 1ns / 1ps
module modbus_rtu_polling_master_core_tb;

   localparam int LIMIT        = 2000000;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE       = 200;
   localparam logic [2:0] NO_OC = 3'd4;

   typedef struct {
      logic [1:0]  kind;
      logic [7:0]  tx;
      logic [3:0]  idx;
      logic [15:0] val;
      logic [1:0]  oc;
      logic        link;
      logic        last;
   } rsp_word_type;

   typedef struct {
      logic [2:0] mode;
      logic [7:0] rx;
      logic [7:0] fl;
      logic [2:0] oc;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   modbus_rtu_polling_master_core DUT (.*);

   // poller image: configuration
   logic [7:0]  cf_slave, cf_gap, cf_maxfail;
   logic [15:0] cf_poll, cf_tmo, cf_floor_reg, cf_emg_reg, cf_insp_reg;
   // poller image: state
   logic [7:0]  rxb [mrpm_pkg::RX_DEPTH];
   int          rx_len;
   logic [7:0]  since_byte;
   logic [15:0] since_poll, since_send;
   logic        awaiting;
   logic [1:0]  rq_kind;
   logic [7:0]  fails, wr_fails;
   logic        link;
   logic [2:0]  pend;
   logic [7:0]  pend_floor;
   logic        pend_insp;
   logic [7:0]  last_req [8];
   logic [2:0]  last_oc;

   rsp_word_type expected_words [$];
   int          errors, n_items, n_words, cycles, n_timeouts, n_bad, n_good;
   bit          quiet, hold, took;
   int          stall;

   function automatic logic [15:0] crc16(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++)
         r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
      return r;
   endfunction

   function automatic void emit(input logic [1:0] kind, input logic [7:0] tx,
                                input logic [3:0] idx, input logic [15:0] val,
                                input logic [1:0] oc);
      rsp_word_type w;
      w.kind = kind; w.tx = tx; w.idx = idx; w.val = val; w.oc = oc;
      w.link = link; w.last = 1'b0;
      expected_words.push_back(w);
      if (kind == mrpm_pkg::KIND_OUTCOME) last_oc = {1'b0, oc};
   endfunction

   function automatic void count_write_retry();
      if (wr_fails != 8'hFF) wr_fails++;
      if (wr_fails >= mrpm_pkg::WRITE_RETRY_LIMIT) begin
         pend = '0;
         wr_fails = '0;
      end
   endfunction

   function automatic void issue_request();
      logic [15:0] addr, val, c;
      logic [7:0]  func;
      func = mrpm_pkg::FUNC_WRITE;
      if (pend[0]) begin
         rq_kind = mrpm_pkg::RK_TARGET; addr = cf_floor_reg; val = {8'h00, pend_floor};
      end else if (pend[1]) begin
         rq_kind = mrpm_pkg::RK_EMG; addr = cf_emg_reg; val = '0;
      end else if (pend[2]) begin
         rq_kind = mrpm_pkg::RK_INSP; addr = cf_insp_reg; val = {15'd0, pend_insp};
      end else begin
         rq_kind = mrpm_pkg::RK_READ; func = mrpm_pkg::FUNC_READ; addr = '0;
         val = 16'(mrpm_pkg::READ_REG_COUNT);
      end
      last_req[0] = cf_slave; last_req[1] = func;
      last_req[2] = addr[15:8]; last_req[3] = addr[7:0];
      last_req[4] = val[15:8]; last_req[5] = val[7:0];
      c = 16'hFFFF;
      for (int i = 0; i < 6; i++) c = crc16(c, last_req[i]);
      last_req[6] = c[7:0]; last_req[7] = c[15:8];
      rx_len = 0; since_poll = '0; since_send = '0; awaiting = 1'b1;
      for (int i = 0; i < 8; i++) emit(mrpm_pkg::KIND_TX, last_req[i], '0, '0, '0);
   endfunction

   function automatic bit answer_valid(input int len);
      logic [15:0] c;
      c = 16'hFFFF;
      if (len < 5) return 0;
      if (rxb[0] != cf_slave) return 0;
      for (int i = 0; i < len - 2; i++) c = crc16(c, rxb[i]);
      if (c != {rxb[len-1], rxb[len-2]}) return 0;
      if (rq_kind == mrpm_pkg::RK_READ)
         return len >= 5 + 2 * mrpm_pkg::READ_REG_COUNT && rxb[1] == mrpm_pkg::FUNC_READ
                && rxb[2] == mrpm_pkg::READ_BYTE_COUNT;
      return rxb[1] == mrpm_pkg::FUNC_WRITE && len >= 8;
   endfunction

   function automatic void close_answer();
      int len;
      len = rx_len;
      rx_len = 0;
      awaiting = 1'b0;
      if (answer_valid(len)) begin
         link = 1'b1; fails = '0; wr_fails = '0;
         n_good++;
         if (rq_kind == mrpm_pkg::RK_READ) begin
            for (int i = 0; i < mrpm_pkg::READ_REG_COUNT; i++)
               emit(mrpm_pkg::KIND_REG, '0, 4'(i), {rxb[3+2*i], rxb[4+2*i]}, '0);
            emit(mrpm_pkg::KIND_OUTCOME, '0, '0, '0, mrpm_pkg::OC_READ_OK);
         end else begin
            pend &= ~(3'b001 << (rq_kind - 2'd1));
            emit(mrpm_pkg::KIND_OUTCOME, '0, '0, '0, mrpm_pkg::OC_WRITE_OK);
         end
      end else begin
         n_bad++;
         if (rq_kind != mrpm_pkg::RK_READ) count_write_retry();
         emit(mrpm_pkg::KIND_OUTCOME, '0, '0, '0, mrpm_pkg::OC_BAD);
      end
   endfunction

   function automatic void tick();
      if (since_poll != 16'hFFFF) since_poll++;
      if (since_byte != 8'hFF) since_byte++;
      if (!awaiting) begin
         if (since_poll >= cf_poll) issue_request();
         return;
      end
      if (since_send != 16'hFFFF) since_send++;
      if (rx_len > 0 && since_byte >= cf_gap) begin
         close_answer();
         return;
      end
      if (since_send >= cf_tmo) begin
         rx_len = 0;
         if (fails != 8'hFF) fails++;
         if (fails >= cf_maxfail) link = 1'b0;
         if (rq_kind != mrpm_pkg::RK_READ) count_write_retry();
         awaiting = 1'b0;
         n_timeouts++;
         emit(mrpm_pkg::KIND_OUTCOME, '0, '0, '0, mrpm_pkg::OC_TIMEOUT);
      end
   endfunction

   function automatic void predict(input logic [2:0] mode, input logic [7:0] b,
                                   input logic [7:0] fl);
      int n0;
      n0 = expected_words.size();
      last_oc = NO_OC;
      case (mode)
         mrpm_pkg::MODE_TICK: tick();
         mrpm_pkg::MODE_BYTE: begin
            if (rx_len < mrpm_pkg::RX_DEPTH) begin
               rxb[rx_len] = b;
               rx_len++;
               since_byte = '0;
            end
         end
         mrpm_pkg::MODE_FLOOR: begin
            if (fl >= 1 && fl <= 3) begin
               pend_floor = fl;
               pend[0] = 1'b1;
            end
         end
         mrpm_pkg::MODE_CLR_EMG: pend[1] = 1'b1;
         mrpm_pkg::MODE_INSP_ON: begin pend_insp = 1'b1; pend[2] = 1'b1; end
         mrpm_pkg::MODE_INSP_OFF: begin pend_insp = 1'b0; pend[2] = 1'b1; end
         default: ;
      endcase
      if (expected_words.size() > n0)
         expected_words[expected_words.size()-1].last = 1'b1;
   endfunction

   task automatic send(input logic [2:0] mode, input logic [7:0] b, input logic [7:0] fl);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 17);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {fl, b};
      req_tuser = mode;
      do @(posedge clock); while (!req_tready);
      predict(mode, b, fl);
      n_items++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] r, input logic [15:0] v);
      @(negedge clock);
      csr_psel = 1'b1; csr_penable = 1'b0; csr_pwrite = 1'b1;
      csr_paddr = {r, 2'b00}; csr_pwdata = {16'd0, v};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (r)
         mrpm_pkg::REG_SLAVE:   cf_slave = v[7:0];
         mrpm_pkg::REG_POLL:    cf_poll = v;
         mrpm_pkg::REG_TIMEOUT: cf_tmo = v;
         mrpm_pkg::REG_GAP:     cf_gap = v[7:0];
         mrpm_pkg::REG_MAXFAIL: cf_maxfail = v[7:0];
         mrpm_pkg::REG_TARGET:  cf_floor_reg = v;
         mrpm_pkg::REG_EMG:     cf_emg_reg = v;
         default:               cf_insp_reg = v;
      endcase
      @(negedge clock);
      csr_psel = 1'b0; csr_penable = 1'b0;
   endtask

   task automatic setup(input logic [7:0] sa, input logic [15:0] poll,
                        input logic [15:0] tmo, input logic [7:0] gap,
                        input logic [7:0] mf, input logic [15:0] fr,
                        input logic [15:0] er, input logic [15:0] ir);
      csr_write(mrpm_pkg::REG_SLAVE, {8'd0, sa});
      csr_write(mrpm_pkg::REG_POLL, poll);
      csr_write(mrpm_pkg::REG_TIMEOUT, tmo);
      csr_write(mrpm_pkg::REG_GAP, {8'd0, gap});
      csr_write(mrpm_pkg::REG_MAXFAIL, {8'd0, mf});
      csr_write(mrpm_pkg::REG_TARGET, fr);
      csr_write(mrpm_pkg::REG_EMG, er);
      csr_write(mrpm_pkg::REG_INSP, ir);
   endtask

   // one poll: optional commands, ticks up to the request, an answer of some kind or none, close
   task automatic poll_round();
      logic [7:0]  fr [$];
      logic [15:0] c;
      int          r, n, k;
      quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(0, 2);
      repeat (n) send(3'($urandom_range(2, 7)), 8'($urandom), 8'($urandom));
      while (!awaiting) send(mrpm_pkg::MODE_TICK, 8'($urandom), 8'($urandom));
      r = $urandom_range(0, 19);
      if (r < 15) begin
         if (rq_kind == mrpm_pkg::RK_READ) begin
            fr.push_back(cf_slave); fr.push_back(mrpm_pkg::FUNC_READ);
            fr.push_back(mrpm_pkg::READ_BYTE_COUNT);
            repeat (2 * mrpm_pkg::READ_REG_COUNT) fr.push_back(8'($urandom));
            c = 16'hFFFF;
            foreach (fr[i]) c = crc16(c, fr[i]);
            fr.push_back(c[7:0]); fr.push_back(c[15:8]);
         end else begin
            for (int i = 0; i < 8; i++) fr.push_back(last_req[i]);
         end
         // damaged answer: one flipped bit
         if (r >= 12) begin
            k = $urandom_range(0, fr.size() - 1);
            fr[k] ^= 8'(1 << $urandom_range(0, 7));
         end
      end else if (r >= 17) begin
         n = $urandom_range(1, 70);
         repeat (n) fr.push_back(8'($urandom));
         if ($urandom_range(0, 1)) fr[0] = cf_slave;
      end
      foreach (fr[i]) send(mrpm_pkg::MODE_BYTE, fr[i], 8'($urandom));
      while (awaiting) send(mrpm_pkg::MODE_TICK, 8'($urandom), 8'($urandom));
   endtask

   function automatic void check_field(input string name, input int e, input int a);
      if (e != a) begin
         $error("%s expected %0h actual %0h", name, e, a);
         errors++;
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("modbus_rtu_polling_master_core: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         took = 1'b1;
         n_words++;
         if (expected_words.size() == 0) begin
            $error("unexpected result word kind %0h data %0h", rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            w = expected_words.pop_front();
            check_field("out_kind", w.kind, rsp_tuser);
            check_field("tx_byte", w.tx, rsp_tdata[7:0]);
            check_field("reg_index", w.idx, rsp_tdata[11:8]);
            check_field("reg_value", w.val, rsp_tdata[27:12]);
            check_field("outcome", w.oc, rsp_tdata[29:28]);
            check_field("link_ok", w.link, rsp_tdata[30]);
            check_field("last", w.last, rsp_tlast);
         end
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold = 1'b0;
         end else begin
            if (took) begin
               took = 1'b0;
               stall = quiet ? 0 : $urandom_range(0, 17);
            end
            if (stall > 0) begin
               rsp_tready = 1'b0;
               stall--;
            end else begin
               rsp_tready = 1'b1;
            end
         end
      end
   end

   initial begin
      stim_row_type rows [25];
      int n0;
      rows = '{
         '{3'd6, 8'h00, 8'h00, NO_OC}, '{3'd7, 8'hFF, 8'hFF, NO_OC},
         '{mrpm_pkg::MODE_FLOOR, 8'h00, 8'h00, NO_OC},
         '{mrpm_pkg::MODE_FLOOR, 8'h00, 8'hFF, NO_OC},
         '{mrpm_pkg::MODE_FLOOR, 8'h00, 8'h03, NO_OC},
         '{mrpm_pkg::MODE_CLR_EMG, 8'h00, 8'h00, NO_OC},
         '{mrpm_pkg::MODE_INSP_ON, 8'h00, 8'h00, NO_OC},
         '{mrpm_pkg::MODE_INSP_OFF, 8'h00, 8'h00, NO_OC},
         // write request, then no answer
         '{mrpm_pkg::MODE_TICK, 8'h00, 8'h00, NO_OC},
         '{mrpm_pkg::MODE_TICK, 8'h00, 8'h00, NO_OC},
         '{mrpm_pkg::MODE_TICK, 8'h00, 8'h00, {1'b0, mrpm_pkg::OC_TIMEOUT}},
         // short answer
         '{mrpm_pkg::MODE_TICK, 8'h00, 8'h00, NO_OC},
         '{mrpm_pkg::MODE_BYTE, 8'h01, 8'h00, NO_OC},
         '{mrpm_pkg::MODE_BYTE, 8'h00, 8'h00, NO_OC},
         '{mrpm_pkg::MODE_BYTE, 8'hFF, 8'h00, NO_OC},
         '{mrpm_pkg::MODE_TICK, 8'h00, 8'h00, {1'b0, mrpm_pkg::OC_BAD}},
         // retries run out, pending writes dropped
         '{mrpm_pkg::MODE_TICK, 8'h00, 8'h00, NO_OC},
         '{mrpm_pkg::MODE_TICK, 8'h00, 8'h00, NO_OC},
         '{mrpm_pkg::MODE_TICK, 8'h00, 8'h00, {1'b0, mrpm_pkg::OC_TIMEOUT}},
         '{mrpm_pkg::MODE_TICK, 8'h00, 8'h00, NO_OC},
         '{mrpm_pkg::MODE_TICK, 8'h00, 8'h00, NO_OC},
         '{mrpm_pkg::MODE_TICK, 8'h00, 8'h00, {1'b0, mrpm_pkg::OC_TIMEOUT}},
         '{mrpm_pkg::MODE_TICK, 8'h00, 8'h00, NO_OC},
         '{mrpm_pkg::MODE_TICK, 8'h00, 8'h00, NO_OC},
         '{mrpm_pkg::MODE_TICK, 8'h00, 8'h00, {1'b0, mrpm_pkg::OC_TIMEOUT}}
      };
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = '0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      cf_slave = 8'd1; cf_poll = 16'd200; cf_tmo = 16'd100; cf_gap = 8'd5;
      cf_maxfail = 8'd3; cf_floor_reg = 16'd1; cf_emg_reg = 16'd3; cf_insp_reg = 16'd7;
      rx_len = 0; since_byte = '0; since_poll = '0; since_send = '0;
      awaiting = 1'b0; rq_kind = mrpm_pkg::RK_READ; fails = '0; wr_fails = '0;
      link = 1'b0;
      pend = '0; pend_floor = '0; pend_insp = 1'b0; last_oc = NO_OC;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset values: four ticks and one idle byte, no poll due yet
      quiet = 1'b1;
      repeat (4) send(mrpm_pkg::MODE_TICK, 8'h00, 8'h00);
      send(mrpm_pkg::MODE_BYTE, 8'hA5, 8'h00);
      settle();

      setup(8'd1, 16'd1, 16'd2, 8'd1, 8'd1, 16'd0, 16'hFFFF, 16'h1234);
      quiet = 1'b0;
      foreach (rows[i]) begin
         send(rows[i].mode, rows[i].rx, rows[i].fl);
         if (rows[i].oc != NO_OC && rows[i].oc != last_oc) begin
            $error("row %0d outcome expected %0h predicted %0h", i, rows[i].oc, last_oc);
            errors++;
         end
      end
      settle();

      setup(8'($urandom_range(2, 246)), 16'd2, 16'd12, 8'd2, 8'd3,
            16'($urandom), 16'($urandom), 16'($urandom));
      n0 = n_items;
      repeat (2) poll_round();
      hold = 1'b1;
      while (n_items < n0 + 60) poll_round();
      settle();

      setup(8'd247, 16'd1, 16'd1, 8'd1, 8'd255, 16'hFFFF, 16'h0000, 16'hFFFF);
      n0 = n_items;
      while (n_items < n0 + 50) poll_round();
      settle();

      // widest timings: nothing comes due, the idle buffer overflows
      setup(8'd1, 16'hFFFF, 16'hFFFF, 8'd255, 8'd1, 16'h0001, 16'h0003, 16'h0007);
      repeat (70) send(mrpm_pkg::MODE_BYTE, 8'($urandom), 8'($urandom));
      repeat (3) send(mrpm_pkg::MODE_TICK, 8'h00, 8'h00);
      send(mrpm_pkg::MODE_INSP_ON, 8'h00, 8'h00);
      settle();

      $display("%0d input words, %0d result words checked", n_items, n_words);
      $display("answers: %0d good, %0d bad, %0d timeouts", n_good, n_bad, n_timeouts);
      if (errors == 0)
         $display("modbus_rtu_polling_master_core: match");
      else
         $display("modbus_rtu_polling_master_core: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/mrpm_pkg.sv
sv/mrpm_crc.sv
sv/mrpm_rxbuf.sv
sv/modbus_rtu_polling_master_core.sv
dv/modbus_rtu_polling_master_core_tb.sv
